[rtl/mbtcp_pkg.sv]
// ============================================================================
// mbtcp_pkg: types and constants of the modbus tcp master framer
// item layouts, frame field codes and register indexes shared by the rtl
// ============================================================================
package mbtcp_pkg;

   // field widths of the register port
   localparam int START_W     = 17;
   localparam int LENGTH_W    = 12;
   localparam int TAG_W       = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_START  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_TAG    = 2'd2;

   // action codes of a request item
   localparam logic [1:0] ACT_POLL  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_RX    = 2'd2;

   // write kinds
   localparam logic [1:0] KIND_BIT   = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_WORD  = 2'd2;
   localparam logic [1:0] KIND_FLOAT = 2'd3;

   // frame field codes
   localparam logic [7:0] FC_READ_HOLD     = 8'h03;
   localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
   localparam logic [7:0] UNIT_ID          = 8'hff;
   localparam logic [7:0] MBAP_LEN_SINGLE  = 8'h06;
   localparam logic [7:0] MBAP_LEN_MULTI   = 8'h0B;
   localparam logic [7:0] FLOAT_REG_COUNT  = 8'h02;
   localparam logic [7:0] FLOAT_BYTE_COUNT = 8'h04;
   localparam logic [15:0] WORD_HI_MASK    = 16'hff00;
   localparam logic [15:0] WORD_LO_MASK    = 16'h00ff;

   // frame lengths
   localparam int FRAME_MAX = 17;
   localparam int FRAME_CNT_W = 5;
   localparam logic [FRAME_CNT_W-1:0] FRAME_LEN_SHORT = 5'd12;
   localparam logic [FRAME_CNT_W-1:0] FRAME_LEN_FLOAT = 5'd17;

   // response parser positions
   localparam int RX_POS_W = 9;
   localparam logic [RX_POS_W-1:0] RX_POS_TAG   = 9'd0;
   localparam logic [RX_POS_W-1:0] RX_POS_FRAME = 9'd1;
   localparam logic [RX_POS_W-1:0] RX_POS_FC    = 9'd7;
   localparam logic [RX_POS_W-1:0] RX_POS_COUNT = 9'd8;
   localparam logic [RX_POS_W-1:0] RX_POS_DATA  = 9'd9;
   localparam logic [RX_POS_W-1:0] RX_POS_LAST  = 9'd511;

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  addr_type;
      logic [15:0] byte_index;
      logic [2:0]  bit_position;
      logic [15:0] set_value;
      logic [31:0] float_bits;
      logic [15:0] device_id;
      logic [7:0]  rx_byte;
      logic        rx_last;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
   } rsp_type;

   // frame bytes, byte 0 is sent first
   typedef logic [FRAME_MAX-1:0][7:0] frame_type;

endpackage

[rtl/modbus_tcp_master_framer.sv]
// ============================================================================
// modbus_tcp_master_framer: modbus tcp request framer with register shadow
// builds read and write request frames and unpacks read responses into a
// synchronous shadow memory of the device's holding registers
// ============================================================================
// A poll item sends the next 12-byte read-holding-registers request of the
// configured region (chunks of FRAME_BYTES bytes, round robin; none for an
// empty region), a write item sends a 12-byte single-register write (bit,
// byte, word) or a 17-byte float write, and a response-byte item feeds the
// parser that fills the shadow. Frame bytes leave one per cycle from an
// output shift register while the receiver does not stall; the next request
// item is accepted while the current frame drains and its frame follows
// without a gap. Response bytes are taken one per cycle unless a request item
// waits for the output or clearing runs; each second data byte of a matching
// reply writes one shadow word. A request item passes the stage-1 register
// (shadow read), then the output register (frame build) before its first byte
// shows. After reset a clearing pass zeroes all SHADOW_WORDS words (1024 by
// default), req_stall high; register writes always taken (csr_ready tied high).
module modbus_tcp_master_framer #(
   parameter int FRAME_BYTES  = 200,
   parameter int SHADOW_WORDS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mbtcp_pkg::req_type                  req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mbtcp_pkg::rsp_type                  rsp_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbtcp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mbtcp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // shadow address width
   localparam int AW = (SHADOW_WORDS > 1) ? $clog2(SHADOW_WORDS) : 1;
   // poll frame index and byte offset widths
   localparam int IDXW = mbtcp_pkg::LENGTH_W;
   localparam int OFFW = $clog2((2 ** mbtcp_pkg::LENGTH_W) + FRAME_BYTES);
   // registers per full chunk
   localparam int HALF_FRAME = (FRAME_BYTES + 1) / 2;
   localparam int PROD_W = IDXW + 8;
   localparam int RX_SUM_W = 17;

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   logic accept;
   logic rsp_acc;
   logic s1_go;
   logic clearing_ff, clearing_in;

   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [mbtcp_pkg::START_W-1:0]  read_start_ff,  read_start_in;
   logic [mbtcp_pkg::LENGTH_W-1:0] read_length_ff, read_length_in;
   logic [mbtcp_pkg::TAG_W-1:0]    read_tag_ff,    read_tag_in;

   always_comb begin
      read_start_in  = read_start_ff;
      read_length_in = read_length_ff;
      read_tag_in    = read_tag_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mbtcp_pkg::CSR_READ_START:  read_start_in  = csr_wdata;
            mbtcp_pkg::CSR_READ_LENGTH: read_length_in = csr_wdata[mbtcp_pkg::LENGTH_W-1:0];
            mbtcp_pkg::CSR_READ_TAG:    read_tag_in    = csr_wdata[mbtcp_pkg::TAG_W-1:0];
            default: ;  // index beyond the register list is ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_start_ff  <= '0;
         read_length_ff <= '0;
         read_tag_ff    <= 8'd1;
      end else begin
         read_start_ff  <= read_start_in;
         read_length_ff <= read_length_in;
         read_tag_ff    <= read_tag_in;
      end
   end

   // ---------------------------------------------------------------------
   // shadow clearing pass after reset
   // ---------------------------------------------------------------------
   logic [AW-1:0] clear_addr_ff, clear_addr_in;

   always_comb begin
      clearing_in   = clearing_ff & (clear_addr_ff != AW'(SHADOW_WORDS - 1));
      clear_addr_in = clearing_ff ? clear_addr_ff + AW'(1) : clear_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // ---------------------------------------------------------------------
   // response parser: header capture and shadow write address
   // ---------------------------------------------------------------------
   logic [mbtcp_pkg::RX_POS_W-1:0] rx_pos_ff, rx_pos_in;
   logic [7:0] rx_tag_ff,   rx_tag_in;
   logic [7:0] rx_frame_ff, rx_frame_in;
   logic [7:0] rx_fc_ff,    rx_fc_in;
   logic [7:0] rx_count_ff, rx_count_in;
   logic [7:0] rx_high_ff,  rx_high_in;

   logic                           rx_acc;
   logic [mbtcp_pkg::RX_POS_W-1:0] rx_k;
   logic                           rx_in_data;
   logic                           rx_match;
   logic [RX_SUM_W-1:0]            rx_sum;
   logic [15:0]                    rx_word;
   logic                           rx_wr;

   always_comb begin
      rx_acc     = accept && (req_item.action == mbtcp_pkg::ACT_RX);
      rx_k       = rx_pos_ff - mbtcp_pkg::RX_POS_DATA;
      rx_in_data = (rx_pos_ff >= mbtcp_pkg::RX_POS_DATA) &&
                   (rx_pos_ff != mbtcp_pkg::RX_POS_LAST);
      rx_match   = (rx_fc_ff == mbtcp_pkg::FC_READ_HOLD) && (rx_tag_ff == read_tag_ff);
      // data byte k pairs into word (frame * FRAME_BYTES + k - 1) / 2
      rx_sum     = RX_SUM_W'(rx_frame_ff) * RX_SUM_W'(FRAME_BYTES) +
                   RX_SUM_W'(rx_k) - RX_SUM_W'(1);
      rx_word    = rx_sum[RX_SUM_W-1:1];
      rx_wr      = rx_acc && rx_in_data && rx_match && rx_k[0] &&
                   (rx_k < {1'b0, rx_count_ff}) &&
                   ({1'b0, rx_word} < 17'(SHADOW_WORDS));

      rx_pos_in   = rx_pos_ff;
      rx_tag_in   = rx_tag_ff;
      rx_frame_in = rx_frame_ff;
      rx_fc_in    = rx_fc_ff;
      rx_count_in = rx_count_ff;
      rx_high_in  = rx_high_ff;
      if (rx_acc) begin
         if (rx_pos_ff == mbtcp_pkg::RX_POS_TAG) begin
            rx_tag_in   = req_item.rx_byte;
            rx_frame_in = '0;
            rx_fc_in    = '0;
            rx_count_in = '0;
         end else if (rx_pos_ff == mbtcp_pkg::RX_POS_FRAME) begin
            rx_frame_in = req_item.rx_byte;
         end else if (rx_pos_ff == mbtcp_pkg::RX_POS_FC) begin
            rx_fc_in = req_item.rx_byte;
         end else if (rx_pos_ff == mbtcp_pkg::RX_POS_COUNT) begin
            rx_count_in = req_item.rx_byte;
         end else if (rx_in_data && rx_match && !rx_k[0]) begin
            rx_high_in = req_item.rx_byte;
         end
         // position saturates, last byte restarts the parser
         if (req_item.rx_last) begin
            rx_pos_in = '0;
         end else if (rx_pos_ff != mbtcp_pkg::RX_POS_LAST) begin
            rx_pos_in = rx_pos_ff + 9'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_pos_ff   <= '0;
         rx_tag_ff   <= '0;
         rx_frame_ff <= '0;
         rx_fc_ff    <= '0;
         rx_count_ff <= '0;
         rx_high_ff  <= '0;
      end else begin
         rx_pos_ff   <= rx_pos_in;
         rx_tag_ff   <= rx_tag_in;
         rx_frame_ff <= rx_frame_in;
         rx_fc_ff    <= rx_fc_in;
         rx_count_ff <= rx_count_in;
         rx_high_ff  <= rx_high_in;
      end
   end

   // ---------------------------------------------------------------------
   // shadow memory: one write port (clear or response), one read port
   // (bit and byte writes read the word at acceptance into a register, used by stage 1 later)
   // ---------------------------------------------------------------------
   logic [15:0] shadow_mem [SHADOW_WORDS];
   logic [15:0] shadow_rd_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [15:0]   mem_wdata;
   logic          mem_re;
   logic [14:0]   wr_word;
   logic [AW-1:0] mem_raddr;
   logic          wr_oor;

   always_comb begin
      mem_we    = clearing_ff | rx_wr;
      mem_waddr = clearing_ff ? clear_addr_ff : rx_word[AW-1:0];
      mem_wdata = clearing_ff ? 16'd0 : {rx_high_ff, req_item.rx_byte};
      mem_re    = accept && (req_item.action == mbtcp_pkg::ACT_WRITE);
      wr_word   = req_item.byte_index[15:1];
      mem_raddr = wr_word[AW-1:0];
      // word outside the shadow reads as zero
      wr_oor    = ({1'b0, wr_word} >= 16'(SHADOW_WORDS));
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         shadow_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         shadow_rd_ff <= shadow_mem[mem_raddr];
      end
   end

   // ---------------------------------------------------------------------
   // stage 1: request item waits here for the shadow word and the output
   // ---------------------------------------------------------------------
   logic                s1_valid_ff, s1_valid_in;
   mbtcp_pkg::req_type  s1_item_ff,  s1_item_in;
   logic                s1_oor_ff,   s1_oor_in;
   logic                s1_load;
   logic                s1_is_poll;
   logic                s1_skip;
   logic                frame_load;

   logic [mbtcp_pkg::FRAME_CNT_W-1:0] rem_ff, rem_in;
   mbtcp_pkg::frame_type              frame_ff, frame_in;
   logic                              buf_free;

   always_comb begin
      rsp_acc    = (rem_ff != '0) && !rsp_stall;
      buf_free   = (rem_ff == '0) || (rsp_acc && (rem_ff == 5'd1));
      s1_is_poll = (s1_item_ff.action == mbtcp_pkg::ACT_POLL);
      // a poll of an empty region gives no frame
      s1_skip    = s1_is_poll && (read_length_ff == '0);
      s1_go      = s1_valid_ff && (s1_skip || buf_free);
      frame_load = s1_go && !s1_skip;
      s1_load    = accept && ((req_item.action == mbtcp_pkg::ACT_POLL) ||
                              (req_item.action == mbtcp_pkg::ACT_WRITE));
      s1_valid_in = s1_load || (s1_valid_ff && !s1_go);
      s1_item_in  = s1_load ? req_item : s1_item_ff;
      s1_oor_in   = s1_load ? wr_oor : s1_oor_ff;
   end

   assign req_stall = clearing_ff | (s1_valid_ff & ~s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s1_oor_ff  <= s1_oor_in;
   end

   // ---------------------------------------------------------------------
   // poll sequencing: frame index and its byte offset move together
   // ---------------------------------------------------------------------
   logic [IDXW-1:0]   poll_idx_ff, poll_idx_in;
   logic [OFFW-1:0]   poll_off_ff, poll_off_in;
   logic [OFFW-1:0]   len_ext;
   logic              poll_stale;
   logic [IDXW-1:0]   eff_idx;
   logic [OFFW-1:0]   eff_off;
   logic [OFFW-1:0]   next_off;
   logic              poll_last;
   logic [OFFW-1:0]   chunk;
   logic [OFFW-1:0]   nreg_sum;
   logic [15:0]       nreg;
   logic [PROD_W-1:0] start_prod;
   logic [15:0]       poll_start;

   always_comb begin
      len_ext    = OFFW'(read_length_ff);
      // index past the chunk count after a region change restarts at zero
      poll_stale = (poll_off_ff >= len_ext);
      eff_idx    = poll_stale ? '0 : poll_idx_ff;
      eff_off    = poll_stale ? '0 : poll_off_ff;
      next_off   = eff_off + OFFW'(FRAME_BYTES);
      poll_last  = (next_off >= len_ext);
      chunk      = poll_last ? (len_ext - eff_off) : OFFW'(FRAME_BYTES);
      nreg_sum   = chunk + OFFW'(1);
      nreg       = 16'(nreg_sum >> 1);
      start_prod = PROD_W'(eff_idx) * PROD_W'(HALF_FRAME);
      poll_start = read_start_ff[mbtcp_pkg::START_W-1:1] + start_prod[15:0];

      poll_idx_in = poll_idx_ff;
      poll_off_in = poll_off_ff;
      if (frame_load && s1_is_poll) begin
         poll_idx_in = poll_last ? '0 : eff_idx + IDXW'(1);
         poll_off_in = poll_last ? '0 : next_off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_idx_ff <= '0;
         poll_off_ff <= '0;
      end else begin
         poll_idx_ff <= poll_idx_in;
         poll_off_ff <= poll_off_in;
      end
   end

   // ---------------------------------------------------------------------
   // frame build: shadow word modify for bit and byte writes
   // ---------------------------------------------------------------------
   logic [15:0]                       base_word;
   logic [3:0]                        bit_sel;
   logic [15:0]                       bit_mask;
   logic [15:0]                       bit_word;
   logic [15:0]                       byte_word;
   logic [15:0]                       wr_value;
   logic [15:0]                       wr_reg;
   mbtcp_pkg::frame_type              frame_new;
   logic [mbtcp_pkg::FRAME_CNT_W-1:0] len_new;

   always_comb begin
      base_word = s1_oor_ff ? 16'd0 : shadow_rd_ff;
      // even byte address is the high byte of its word
      bit_sel   = {~s1_item_ff.byte_index[0], s1_item_ff.bit_position};
      bit_mask  = 16'd1 << bit_sel;
      bit_word  = (s1_item_ff.set_value == 16'd1) ? (base_word | bit_mask)
                                                  : (base_word & ~bit_mask);
      byte_word = s1_item_ff.byte_index[0]
                  ? {base_word[15:8], s1_item_ff.set_value[7:0]}
                  : {s1_item_ff.set_value[7:0], base_word[7:0]};

      wr_value = s1_item_ff.set_value;
      wr_reg   = s1_item_ff.byte_index;
      case (s1_item_ff.addr_type)
         mbtcp_pkg::KIND_BIT: begin
            wr_value = bit_word;
            wr_reg   = {1'b0, s1_item_ff.byte_index[15:1]};
         end
         mbtcp_pkg::KIND_BYTE: begin
            wr_value = byte_word;
            wr_reg   = {1'b0, s1_item_ff.byte_index[15:1]};
         end
         mbtcp_pkg::KIND_WORD: begin
            wr_value = s1_item_ff.set_value;
            wr_reg   = s1_item_ff.byte_index;
         end
         mbtcp_pkg::KIND_FLOAT: begin
            wr_value = s1_item_ff.set_value;
            wr_reg   = {s1_item_ff.byte_index[14:0], 1'b0};
         end
      endcase

      frame_new = '0;
      len_new   = mbtcp_pkg::FRAME_LEN_SHORT;
      frame_new[6] = mbtcp_pkg::UNIT_ID;
      if (s1_is_poll) begin
         frame_new[0]  = read_tag_ff;
         frame_new[1]  = eff_idx[7:0];
         frame_new[5]  = mbtcp_pkg::MBAP_LEN_SINGLE;
         frame_new[7]  = mbtcp_pkg::FC_READ_HOLD;
         frame_new[8]  = poll_start[15:8];
         frame_new[9]  = poll_start[7:0];
         frame_new[10] = nreg[15:8];
         frame_new[11] = nreg[7:0];
      end else begin
         frame_new[0] = s1_item_ff.device_id[15:8];
         frame_new[1] = s1_item_ff.device_id[7:0];
         frame_new[8] = wr_reg[15:8];
         frame_new[9] = wr_reg[7:0];
         if (s1_item_ff.addr_type == mbtcp_pkg::KIND_FLOAT) begin
            len_new       = mbtcp_pkg::FRAME_LEN_FLOAT;
            frame_new[5]  = mbtcp_pkg::MBAP_LEN_MULTI;
            frame_new[7]  = mbtcp_pkg::FC_WRITE_MULTI;
            frame_new[11] = mbtcp_pkg::FLOAT_REG_COUNT;
            frame_new[12] = mbtcp_pkg::FLOAT_BYTE_COUNT;
            // low word first, high byte first within each word
            frame_new[13] = s1_item_ff.float_bits[15:8];
            frame_new[14] = s1_item_ff.float_bits[7:0];
            frame_new[15] = s1_item_ff.float_bits[31:24];
            frame_new[16] = s1_item_ff.float_bits[23:16];
         end else begin
            frame_new[5]  = mbtcp_pkg::MBAP_LEN_SINGLE;
            frame_new[7]  = mbtcp_pkg::FC_WRITE_SINGLE;
            frame_new[10] = 8'((wr_value & mbtcp_pkg::WORD_HI_MASK) >> 8);
            frame_new[11] = 8'(wr_value & mbtcp_pkg::WORD_LO_MASK);
         end
      end
   end

   // ---------------------------------------------------------------------
   // output shift register: byte 0 is on the port, rem_ff bytes remain
   // ---------------------------------------------------------------------
   always_comb begin
      rem_in   = rem_ff;
      frame_in = frame_ff;
      if (frame_load) begin
         rem_in   = len_new;
         frame_in = frame_new;
      end else if (rsp_acc) begin
         rem_in   = rem_ff - 5'd1;
         frame_in = frame_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign rsp_valid           = (rem_ff != '0);
   assign rsp_item.frame_byte = frame_ff[0];
   assign rsp_item.frame_last = (rem_ff == 5'd1);

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // a frame never breaks up between its bytes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_item.frame_last) |=> rsp_valid)
      else $error("frame interrupted before its last byte");

   // a frame starts only with a full request length
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ((rem_ff == mbtcp_pkg::FRAME_LEN_SHORT) ||
                            (rem_ff == mbtcp_pkg::FRAME_LEN_FLOAT)))
      else $error("frame started with a bad length");

   // nothing is in flight while the shadow is being cleared
   assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (!s1_valid_ff && !rsp_valid && !rx_wr))
      else $error("activity during the shadow clearing pass");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench of the modbus tcp master framer
// sends poll, write and response-byte items in random bursts, keeps its own
// copy of the register shadow and poll state to predict every frame byte, and
// checks the outgoing bytes in order while the receiver stalls at random
// ============================================================================
module tb;

   localparam int FRAME_BYTES   = 200;
   localparam int SHADOW_WORDS  = 1024;
   localparam int CHUNK_REGS    = (FRAME_BYTES + 1) / 2;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_PRINTS    = 40;

   // action code that the block ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                              clock;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   mbtcp_pkg::req_type                req_item  = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   mbtcp_pkg::rsp_type                rsp_item;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [mbtcp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mbtcp_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // predicted device view: shadow words, poll rotation, response parser
   logic [15:0]                    shadow_copy [SHADOW_WORDS];
   logic [3:0]                     next_chunk = '0;
   logic [mbtcp_pkg::RX_POS_W-1:0] parse_pos  = '0;
   logic [31:0]                    parse_hdr  = '0;
   logic [7:0]                     parse_hi   = '0;

   // register copies
   logic [mbtcp_pkg::START_W-1:0]  cfg_start  = '0;
   logic [mbtcp_pkg::LENGTH_W-1:0] cfg_length = '0;
   logic [mbtcp_pkg::TAG_W-1:0]    cfg_tag    = 8'd1;

   mbtcp_pkg::rsp_type frame_bytes_due [$];
   logic [7:0]         frame_buf [mbtcp_pkg::FRAME_MAX];
   int                 mismatches  = 0;
   int                 cycle_count = 0;
   int                 items_sent  = 0;
   int                 burst_left  = 0;
   stall_mode_type     stall_mode  = STALL_NONE;
   int                 stall_left  = 0;

   modbus_tcp_master_framer #(
      .FRAME_BYTES  (FRAME_BYTES),
      .SHADOW_WORDS (SHADOW_WORDS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // ---------------------------------------------------------------------
   // frame prediction
   // ---------------------------------------------------------------------
   task automatic queue_frame(input int n);
      mbtcp_pkg::rsp_type entry;
      for (int k = 0; k < n; k++) begin
         entry.frame_byte = frame_buf[k];
         entry.frame_last = (k == n - 1);
         frame_bytes_due.insert(frame_bytes_due.size(), entry);
      end
   endtask

   task automatic set_header(input logic [15:0] id, input logic [7:0] len,
                             input logic [7:0] fc, input logic [15:0] first_reg);
      frame_buf[0] = id[15:8];
      frame_buf[1] = id[7:0];
      frame_buf[2] = 8'h00;
      frame_buf[3] = 8'h00;
      frame_buf[4] = 8'h00;
      frame_buf[5] = len;
      frame_buf[6] = mbtcp_pkg::UNIT_ID;
      frame_buf[7] = fc;
      frame_buf[8] = first_reg[15:8];
      frame_buf[9] = first_reg[7:0];
   endtask

   task automatic predict_poll_frame();
      int          chunks, chunk_len, nreg, idx;
      logic [15:0] first_reg;
      // empty region: nothing goes out
      if (cfg_length == 0)
         return;
      chunks = (int'(cfg_length) + FRAME_BYTES - 1) / FRAME_BYTES;
      // a region that shrank leaves a stale chunk index behind
      if (int'(next_chunk) >= chunks)
         next_chunk = '0;
      idx = int'(next_chunk);
      chunk_len = (idx + 1 < chunks) ? FRAME_BYTES : int'(cfg_length) - idx * FRAME_BYTES;
      nreg = (chunk_len + 1) / 2;
      first_reg = 16'(int'(cfg_start) / 2 + idx * CHUNK_REGS);
      set_header({cfg_tag, 8'(idx)}, mbtcp_pkg::MBAP_LEN_SINGLE, mbtcp_pkg::FC_READ_HOLD,
                 first_reg);
      frame_buf[10] = 8'(nreg >> 8);
      frame_buf[11] = 8'(nreg);
      next_chunk = (idx + 1 >= chunks) ? 4'd0 : 4'(idx + 1);
      queue_frame(int'(mbtcp_pkg::FRAME_LEN_SHORT));
   endtask

   task automatic predict_write_frame(input mbtcp_pkg::req_type r);
      logic [15:0] reg_addr;
      logic [15:0] word;
      int          shift;
      if (r.addr_type == mbtcp_pkg::KIND_FLOAT) begin
         reg_addr = {r.byte_index[14:0], 1'b0};
         set_header(r.device_id, mbtcp_pkg::MBAP_LEN_MULTI, mbtcp_pkg::FC_WRITE_MULTI,
                    reg_addr);
         frame_buf[10] = 8'h00;
         frame_buf[11] = mbtcp_pkg::FLOAT_REG_COUNT;
         frame_buf[12] = mbtcp_pkg::FLOAT_BYTE_COUNT;
         // low word first, each word high byte first
         frame_buf[13] = r.float_bits[15:8];
         frame_buf[14] = r.float_bits[7:0];
         frame_buf[15] = r.float_bits[31:24];
         frame_buf[16] = r.float_bits[23:16];
         queue_frame(int'(mbtcp_pkg::FRAME_LEN_FLOAT));
         return;
      end
      if (r.addr_type == mbtcp_pkg::KIND_WORD) begin
         reg_addr = r.byte_index;
         word = r.set_value;
      end else begin
         // bit and byte writes patch the shadow word but leave it unchanged
         reg_addr = {1'b0, r.byte_index[15:1]};
         word = (reg_addr < SHADOW_WORDS) ? shadow_copy[reg_addr] : 16'h0000;
         shift = r.byte_index[0] ? 0 : 8;
         if (r.addr_type == mbtcp_pkg::KIND_BIT)
            word[int'(r.bit_position) + shift] = (r.set_value == 16'd1);
         else
            word = (word & ~(mbtcp_pkg::WORD_LO_MASK << shift)) |
                   ({8'h00, r.set_value[7:0]} << shift);
      end
      set_header(r.device_id, mbtcp_pkg::MBAP_LEN_SINGLE, mbtcp_pkg::FC_WRITE_SINGLE,
                 reg_addr);
      frame_buf[10] = word[15:8];
      frame_buf[11] = word[7:0];
      queue_frame(int'(mbtcp_pkg::FRAME_LEN_SHORT));
   endtask

   task automatic track_response_byte(input mbtcp_pkg::req_type r);
      int k, word_idx;
      case (parse_pos)
         mbtcp_pkg::RX_POS_TAG:   parse_hdr        = {r.rx_byte, 24'h000000};
         mbtcp_pkg::RX_POS_FRAME: parse_hdr[23:16] = r.rx_byte;
         mbtcp_pkg::RX_POS_FC:    parse_hdr[15:8]  = r.rx_byte;
         mbtcp_pkg::RX_POS_COUNT: parse_hdr[7:0]   = r.rx_byte;
         default: begin
            if (parse_pos >= mbtcp_pkg::RX_POS_DATA && parse_pos < mbtcp_pkg::RX_POS_LAST &&
                parse_hdr[15:8] == mbtcp_pkg::FC_READ_HOLD &&
                parse_hdr[31:24] == cfg_tag) begin
               k = int'(parse_pos) - int'(mbtcp_pkg::RX_POS_DATA);
               if (k % 2 == 0) begin
                  parse_hi = r.rx_byte;
               end else if (k < int'(parse_hdr[7:0])) begin
                  word_idx = (int'(parse_hdr[23:16]) * FRAME_BYTES + k - 1) / 2;
                  if (word_idx < SHADOW_WORDS)
                     shadow_copy[word_idx] = {parse_hi, r.rx_byte};
               end
            end
         end
      endcase
      if (r.rx_last)
         parse_pos = mbtcp_pkg::RX_POS_TAG;
      else if (parse_pos < mbtcp_pkg::RX_POS_LAST)
         parse_pos++;
   endtask

   // ---------------------------------------------------------------------
   // stimulus plumbing
   // ---------------------------------------------------------------------
   function automatic mbtcp_pkg::req_type make_item(input logic [1:0] act);
      mbtcp_pkg::req_type r;
      // fields the action does not use still carry random bits
      r = mbtcp_pkg::req_type'({$urandom, $urandom, $urandom});
      r.action = act;
      return r;
   endfunction

   // bursts of random length with random gaps; predicted at acceptance
   task automatic send_item(input mbtcp_pkg::req_type r);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item  <= r;
      do @(posedge clock); while (req_stall);
      if (r.action != ACT_UNUSED)
         items_sent++;
      case (r.action)
         mbtcp_pkg::ACT_POLL:  predict_poll_frame();
         mbtcp_pkg::ACT_WRITE: predict_write_frame(r);
         mbtcp_pkg::ACT_RX:    track_response_byte(r);
         default:              ;
      endcase
   endtask

   task automatic send_write(input logic [1:0] kind, input logic [15:0] index,
                             input logic [2:0] bit_pos, input logic [15:0] value,
                             input logic [31:0] fbits, input logic [15:0] dev);
      mbtcp_pkg::req_type r;
      r = make_item(mbtcp_pkg::ACT_WRITE);
      r.addr_type    = kind;
      r.byte_index   = index;
      r.bit_position = bit_pos;
      r.set_value    = value;
      r.float_bits   = fbits;
      r.device_id    = dev;
      send_item(r);
   endtask

   task automatic send_rx(input logic [7:0] b, input logic last);
      mbtcp_pkg::req_type r;
      r = make_item(mbtcp_pkg::ACT_RX);
      r.rx_byte = b;
      r.rx_last = last;
      send_item(r);
   endtask

   // response frame: header bytes the parser skips are random
   task automatic send_response(input logic [7:0] tag, input logic [7:0] frame,
                                input logic [7:0] fc, input logic [7:0] data_count,
                                input int data_len);
      int         total;
      logic [7:0] b;
      total = int'(mbtcp_pkg::RX_POS_DATA) + data_len;
      for (int p = 0; p < total; p++) begin
         if (p == mbtcp_pkg::RX_POS_TAG)
            b = tag;
         else if (p == mbtcp_pkg::RX_POS_FRAME)
            b = frame;
         else if (p == mbtcp_pkg::RX_POS_FC)
            b = fc;
         else if (p == mbtcp_pkg::RX_POS_COUNT)
            b = data_count;
         else
            b = 8'($urandom);
         send_rx(b, p == total - 1);
      end
   endtask

   // drop valid, let every pending frame drain, then let the parser settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [mbtcp_pkg::START_W-1:0] start,
                            input logic [mbtcp_pkg::LENGTH_W-1:0] length,
                            input logic [mbtcp_pkg::TAG_W-1:0] tag);
      logic [mbtcp_pkg::CSR_INDEX_W-1:0] order [3];
      logic [mbtcp_pkg::CSR_DATA_W-1:0]  values [3];
      wait_idle();
      order  = '{mbtcp_pkg::CSR_READ_START, mbtcp_pkg::CSR_READ_LENGTH,
                 mbtcp_pkg::CSR_READ_TAG};
      values = '{start, mbtcp_pkg::CSR_DATA_W'(length), mbtcp_pkg::CSR_DATA_W'(tag)};
      csr_valid <= 1'b1;
      foreach (order[i]) begin
         csr_index <= order[i];
         csr_wdata <= values[i];
         do @(posedge clock); while (!csr_ready);
         case (order[i])
            mbtcp_pkg::CSR_READ_START:  cfg_start  = values[i][mbtcp_pkg::START_W-1:0];
            mbtcp_pkg::CSR_READ_LENGTH: cfg_length = values[i][mbtcp_pkg::LENGTH_W-1:0];
            mbtcp_pkg::CSR_READ_TAG:    cfg_tag    = values[i][mbtcp_pkg::TAG_W-1:0];
            default:                    ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // receiver: stall pattern changes to a random mode after a random stretch
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ~rsp_stall;
      endcase
   end

   // every accepted frame byte is matched against the oldest prediction
   always @(posedge clock) begin : check_frame_bytes
      mbtcp_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_bytes_due.size() == 0) begin
            report_mismatch($sformatf("unexpected frame byte %h last %b",
                                      rsp_item.frame_byte, rsp_item.frame_last));
         end else begin
            want = frame_bytes_due.pop_front();
            if (rsp_item.frame_byte !== want.frame_byte)
               report_mismatch($sformatf("frame_byte got %h want %h",
                                         rsp_item.frame_byte, want.frame_byte));
            if (rsp_item.frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last got %b want %b",
                                         rsp_item.frame_last, want.frame_last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // writes against the cleared shadow, field extremes, ignored items
   task automatic test_writes_on_clear_shadow();
      send_item(make_item(ACT_UNUSED));
      send_item(make_item(mbtcp_pkg::ACT_POLL));  // region still empty
      send_write(mbtcp_pkg::KIND_BIT,   16'd0,    3'd7, 16'd1,    32'h0000_0000, 16'h0000);
      send_write(mbtcp_pkg::KIND_BIT,   16'hffff, 3'd0, 16'd1,    32'hffff_ffff, 16'hffff);
      send_write(mbtcp_pkg::KIND_BIT,   16'd1,    3'd3, 16'd2,    32'h0, 16'h1234);
      send_write(mbtcp_pkg::KIND_BIT,   16'd6,    3'd4, 16'hffff, 32'h0, 16'h00ff);
      send_write(mbtcp_pkg::KIND_BYTE,  16'd2,    3'd0, 16'hffff, 32'h0, 16'hff00);
      send_write(mbtcp_pkg::KIND_BYTE,  16'hfffe, 3'd1, 16'h5aa5, 32'h0, 16'h8001);
      send_write(mbtcp_pkg::KIND_WORD,  16'd0,    3'd2, 16'h0000, 32'h0, 16'h0001);
      send_write(mbtcp_pkg::KIND_WORD,  16'hffff, 3'd5, 16'hffff, 32'h0, 16'hfffe);
      send_write(mbtcp_pkg::KIND_FLOAT, 16'd0,    3'd6, 16'h0,    32'h0000_0000, 16'h0102);
      send_write(mbtcp_pkg::KIND_FLOAT, 16'hffff, 3'd6, 16'h0,    32'hffff_ffff, 16'hffff);
      send_write(mbtcp_pkg::KIND_FLOAT, 16'h1234, 3'd6, 16'h0,    32'h3f80_0001, 16'h7e7f);
   endtask

   // chunk rotation, address wrap, stale chunk index, one-byte region
   task automatic test_poll_rotation();
      configure(17'd131070, 12'd401, 8'hff);
      repeat (4) send_item(make_item(mbtcp_pkg::ACT_POLL));
      configure(17'd1, 12'd2048, 8'h00);
      repeat (3) send_item(make_item(mbtcp_pkg::ACT_POLL));
      configure(17'd0, 12'd200, 8'h80);
      repeat (2) send_item(make_item(mbtcp_pkg::ACT_POLL));
      configure(17'd5, 12'd1, 8'h01);
      send_item(make_item(mbtcp_pkg::ACT_POLL));
   endtask

   // responses fill the shadow, then bit and byte writes read it back
   task automatic test_response_unpacking();
      configure(17'd0, 12'd400, 8'h5a);
      send_response(8'h5a, 8'd0,   mbtcp_pkg::FC_READ_HOLD,    8'd4, 5);  // trailing half pair
      send_response(8'h5a, 8'd1,   mbtcp_pkg::FC_READ_HOLD,    8'd2, 2);
      send_response(8'h5b, 8'd0,   mbtcp_pkg::FC_READ_HOLD,    8'd4, 4);  // foreign tag
      send_response(8'h5a, 8'd0,   mbtcp_pkg::FC_WRITE_SINGLE, 8'd4, 4);  // not a read reply
      send_response(8'h5a, 8'd255, mbtcp_pkg::FC_READ_HOLD,    8'd2, 2);  // beyond the shadow
      send_rx(8'h5a, 1'b1);                                               // cut off after tag
      send_write(mbtcp_pkg::KIND_BYTE, 16'd0,   3'd0, 16'h00c3, 32'h0, 16'h0011);
      send_write(mbtcp_pkg::KIND_BYTE, 16'd3,   3'd0, 16'h003c, 32'h0, 16'h0022);
      send_write(mbtcp_pkg::KIND_BIT,  16'd200, 3'd5, 16'd0,    32'h0, 16'h0033);
      send_write(mbtcp_pkg::KIND_BIT,  16'd201, 3'd2, 16'd1,    32'h0, 16'h0044);
   endtask

   // a response whose count runs past its data, then a short one
   task automatic test_long_response();
      send_response(cfg_tag, 8'd2, mbtcp_pkg::FC_READ_HOLD, 8'hff, 40);
      send_response(cfg_tag, 8'd0, mbtcp_pkg::FC_READ_HOLD, 8'd2, 2);
      send_write(mbtcp_pkg::KIND_BYTE, 16'd400, 3'd0, 16'h0077, 32'h0, 16'h0055);
      send_write(mbtcp_pkg::KIND_BIT,  16'd653, 3'd7, 16'd1,    32'h0, 16'h0066);
      send_write(mbtcp_pkg::KIND_BYTE, 16'd1,   3'd0, 16'h0088, 32'h0, 16'h0077);
   endtask

   // mostly well-formed traffic with random content, some noise
   task automatic random_phase(input int budget);
      int                 stop_at, pick, data_len;
      logic [7:0]         data_count, tag, frame, fc;
      mbtcp_pkg::req_type r;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_item(make_item(mbtcp_pkg::ACT_POLL));
         end else if (pick < 75) begin
            r = make_item(mbtcp_pkg::ACT_WRITE);
            // aim half the writes at words that responses fill
            if ($urandom_range(0, 1) == 0)
               r.byte_index = 16'($urandom_range(0, 10) * FRAME_BYTES + $urandom_range(0, 31));
            if (r.addr_type == mbtcp_pkg::KIND_BIT && $urandom_range(0, 3) != 0)
               r.set_value = 16'($urandom_range(0, 1));
            send_item(r);
         end else if (pick < 87) begin
            data_len   = $urandom_range(0, 18);
            data_count = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(data_len & ~1);
            tag   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : cfg_tag;
            fc    = ($urandom_range(0, 4) == 0) ? 8'($urandom) : mbtcp_pkg::FC_READ_HOLD;
            frame = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
            send_response(tag, frame, fc, data_count, data_len);
         end else if (pick < 95) begin
            send_item(make_item(mbtcp_pkg::ACT_RX));
         end else begin
            send_item(make_item(ACT_UNUSED));
         end
      end
   endtask

   task automatic test_random_traffic();
      configure(17'($urandom_range(0, 131070)), 12'd2048, 8'($urandom));
      random_phase(25);
      configure(17'd0, 12'($urandom_range(1, 600)), 8'h00);
      random_phase(25);
      configure(17'd131070, 12'($urandom_range(1, 2048)), 8'hff);
      random_phase(25);
      configure(17'($urandom_range(0, 131070)), 12'd0, 8'($urandom));
      random_phase(20);
      repeat (3) begin
         configure(17'($urandom_range(0, 131070)), 12'($urandom_range(1, 2048)),
                   8'($urandom));
         random_phase(15);
      end
   endtask

   initial begin
      foreach (shadow_copy[i])
         shadow_copy[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_writes_on_clear_shadow();
      test_poll_rotation();
      test_response_unpacking();
      test_long_response();
      test_random_traffic();
      wait_idle();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/mbtcp_pkg.sv
rtl/modbus_tcp_master_framer.sv
test/tb.sv
